// ----- rtl/rfgb_pkg.sv -----
// Shared types, constants and helpers for the rectangle fill / gray blit core.
// No dependencies; imported by rfgb_walker and rect_fill_and_gray_blit_core.
package rfgb_pkg;

	// Field widths
	localparam int unsigned POS_W   = 12;  // dest_x, dest_y
	localparam int unsigned DIM_W   = 13;  // rectangle and surface sizes
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned ADDR_W  = 24;
	localparam int unsigned CFG_W   = 13;  // widest register
	localparam int unsigned CIDX_W  = 3;

	// Largest rectangle side accepted before clamping
	localparam int unsigned MAX_DIM_DEF = 4096;

	// Alpha in gray mode
	localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;

	// Register map
	typedef enum logic [CIDX_W-1:0] {
		CFG_DEST_X         = 3'd0,
		CFG_DEST_Y         = 3'd1,
		CFG_RECT_WIDTH     = 3'd2,
		CFG_RECT_HEIGHT    = 3'd3,
		CFG_SURFACE_WIDTH  = 3'd4,
		CFG_SURFACE_HEIGHT = 3'd5,
		CFG_FILL_MODE      = 3'd6,
		CFG_FILL_LEVEL     = 3'd7
	} cfg_idx_t;

	// Walk position handed from the walker to the datapath
	typedef struct packed {
		logic [DIM_W-1:0] col;
		logic [DIM_W-1:0] row;
		logic             last;
	} walk_pos_t;

	// Zero becomes one, anything above max_dim becomes max_dim
	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
	                                             input int unsigned max_dim);
		logic [31:0] v_ext;
		v_ext = 32'(v);
		if (v == '0) begin
			return DIM_W'(1);
		end else if (v_ext > max_dim) begin
			return DIM_W'(max_dim);
		end else begin
			return v;
		end
	endfunction

endpackage

// ----- rtl/rfgb_walker.sv -----
// Row-major walk over the rectangle: column and row offset counters.
// Depends on rfgb_pkg.
module rfgb_walker import rfgb_pkg::*; #(
	parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic             restart,
	input  logic [DIM_W-1:0] w_eff,
	input  logic [DIM_W-1:0] h_eff,
	output walk_pos_t        pos
);

	// Offsets never exceed min(MAX_DIM, 8191) - 1
	localparam int unsigned OFF_W = ($clog2(MAX_DIM) < DIM_W) ? $clog2(MAX_DIM) : DIM_W;

	logic [OFF_W-1:0] col_q;
	logic [OFF_W-1:0] row_q;
	logic [DIM_W-1:0] col_ext;
	logic [DIM_W-1:0] row_ext;
	logic             col_end;
	logic             row_end;

	// End of row / end of rectangle
	always_comb begin
		col_ext = DIM_W'(col_q);
		row_ext = DIM_W'(row_q);
		col_end = (col_ext == w_eff - DIM_W'(1));
		row_end = (row_ext == h_eff - DIM_W'(1));
	end

	assign pos.col  = col_ext;
	assign pos.row  = row_ext;
	assign pos.last = col_end && row_end;

	// Offset counters; wrap to the top-left corner after the last pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (!col_end) begin
				col_q <= col_q + OFF_W'(1);
			end else begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + OFF_W'(1);
			end
		end
	end

endmodule

// ----- rtl/rect_fill_and_gray_blit_core.sv -----
// Rectangle fill / gray copy blitter for a 32-bit BGRA surface.
// An accepted input beat's result is registered and appears on the output in the following cycle.
// Throughput: one pixel per clock; the result register is taken and refilled
// in the same cycle, and a stall on the output holds the input.
// Reset: registers to 0,0,1,1,1,1,0,0, walk at the top-left, output empty.
// Depends on rfgb_pkg and rfgb_walker.
module rect_fill_and_gray_blit_core import rfgb_pkg::*; #(
	parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// Configuration write port
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	// Input channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] source_gray,
	// Output channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic [ADDR_W-1:0] pixel_addr,
	output logic [BYTE_W-1:0] blue,
	output logic [BYTE_W-1:0] green,
	output logic [BYTE_W-1:0] red,
	output logic [BYTE_W-1:0] alpha,
	output logic              write_enable,
	output logic              bounds_error,
	output logic              last_pixel
);

	localparam int unsigned SUM_W  = DIM_W + 1;          // coordinate / bound sums
	localparam int unsigned PROD_W = SUM_W + DIM_W;      // y * pitch

	// Configuration registers
	logic [POS_W-1:0]  dest_x_q;
	logic [POS_W-1:0]  dest_y_q;
	logic [DIM_W-1:0]  rect_width_q;
	logic [DIM_W-1:0]  rect_height_q;
	logic [DIM_W-1:0]  surface_width_q;
	logic [DIM_W-1:0]  surface_height_q;
	logic              fill_mode_q;
	logic [BYTE_W-1:0] fill_level_q;

	// Datapath
	logic [DIM_W-1:0]  w_eff;
	logic [DIM_W-1:0]  h_eff;
	walk_pos_t         pos;
	logic              accept;
	logic              err;
	logic [SUM_W-1:0]  x_sum;
	logic [SUM_W-1:0]  y_sum;
	logic [PROD_W-1:0] row_base;
	logic [PROD_W-1:0] addr_full;
	logic [BYTE_W-1:0] chan_byte;
	logic [BYTE_W-1:0] alpha_byte;

	// Result register
	logic              out_valid_q;
	logic [ADDR_W-1:0] pixel_addr_q;
	logic [BYTE_W-1:0] chan_q;
	logic [BYTE_W-1:0] alpha_q;
	logic              err_q;
	logic              last_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_x_q         <= '0;
			dest_y_q         <= '0;
			rect_width_q     <= DIM_W'(1);
			rect_height_q    <= DIM_W'(1);
			surface_width_q  <= DIM_W'(1);
			surface_height_q <= DIM_W'(1);
			fill_mode_q      <= 1'b0;
			fill_level_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_DEST_X:         dest_x_q         <= cfg_data[POS_W-1:0];
				CFG_DEST_Y:         dest_y_q         <= cfg_data[POS_W-1:0];
				CFG_RECT_WIDTH:     rect_width_q     <= cfg_data[DIM_W-1:0];
				CFG_RECT_HEIGHT:    rect_height_q    <= cfg_data[DIM_W-1:0];
				CFG_SURFACE_WIDTH:  surface_width_q  <= cfg_data[DIM_W-1:0];
				CFG_SURFACE_HEIGHT: surface_height_q <= cfg_data[DIM_W-1:0];
				CFG_FILL_MODE:      fill_mode_q      <= cfg_data[0];
				CFG_FILL_LEVEL:     fill_level_q     <= cfg_data[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshake: result register frees up when taken
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	// Effective rectangle size
	assign w_eff = eff_dim(rect_width_q, MAX_DIM);
	assign h_eff = eff_dim(rect_height_q, MAX_DIM);

	rfgb_walker #(
		.MAX_DIM(MAX_DIM)
	) u_walker (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(accept),
		.restart(cfg_we),
		.w_eff  (w_eff),
		.h_eff  (h_eff),
		.pos    (pos)
	);

	// Bounds check, address and channel bytes
	always_comb begin
		err = (SUM_W'(dest_x_q) + SUM_W'(w_eff) > SUM_W'(surface_width_q)) ||
		      (SUM_W'(dest_y_q) + SUM_W'(h_eff) > SUM_W'(surface_height_q));
		x_sum     = SUM_W'(dest_x_q) + SUM_W'(pos.col);
		y_sum     = SUM_W'(dest_y_q) + SUM_W'(pos.row);
		row_base  = PROD_W'(y_sum) * PROD_W'(surface_width_q);
		addr_full = row_base + PROD_W'(x_sum);
		if (fill_mode_q) begin
			chan_byte  = fill_level_q;
			alpha_byte = fill_level_q;
		end else begin
			chan_byte  = source_gray;
			alpha_byte = ALPHA_OPAQUE;
		end
	end

	// Result register: valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register: payload
	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_addr_q <= addr_full[ADDR_W-1:0];
			chan_q       <= chan_byte;
			alpha_q      <= alpha_byte;
			err_q        <= err;
			last_q       <= pos.last;
		end
	end

	assign out_valid    = out_valid_q;
	assign pixel_addr   = pixel_addr_q;
	assign blue         = chan_q;
	assign green        = chan_q;
	assign red          = chan_q;
	assign alpha        = alpha_q;
	assign write_enable = !err_q;
	assign bounds_error = err_q;
	assign last_pixel   = last_q;

endmodule

// ----- verif/tb_rect_fill_and_gray_blit_core.sv -----
// Self-checking testbench for rect_fill_and_gray_blit_core: directed table, then random rectangles.
// A local model of the pixel walk predicts every write beat. Uses rfgb_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_rect_fill_and_gray_blit_core;
	import rfgb_pkg::*;

	// One write beat as seen on the output channel
	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] b;
		logic [BYTE_W-1:0] g;
		logic [BYTE_W-1:0] r;
		logic [BYTE_W-1:0] a;
		logic              we;
		logic              err;
		logic              last;
	} blit_write_t;

	// Directed row: a register write or a pixel, optionally with a hand-typed result
	typedef struct {
		bit                is_cfg;
		cfg_idx_t          idx;
		logic [CFG_W-1:0]  data;
		logic [BYTE_W-1:0] gray;
		bit                typed;
		blit_write_t       res;
	} step_row_t;

	logic              clk;
	logic              arst_n      = 1'b0;
	logic              cfg_we      = 1'b0;
	logic [CIDX_W-1:0] cfg_index   = '0;
	logic [CFG_W-1:0]  cfg_data    = '0;
	logic              in_valid    = 1'b0;
	logic              in_stall;
	logic [BYTE_W-1:0] source_gray = '0;
	logic              out_valid;
	logic              out_stall   = 1'b0;
	logic [ADDR_W-1:0] pixel_addr;
	logic [BYTE_W-1:0] blue, green, red, alpha;
	logic              write_enable, bounds_error, last_pixel;

	// Local copy of the register file and the walk position
	logic [POS_W-1:0]  reg_dx = '0, reg_dy = '0;
	logic [DIM_W-1:0]  reg_rw = 13'd1, reg_rh = 13'd1, reg_sw = 13'd1, reg_sh = 13'd1;
	logic              reg_fill_mode = 1'b0;
	logic [BYTE_W-1:0] reg_fill_level = '0;
	int unsigned       walk_col = 0, walk_row = 0;

	blit_write_t due_writes[$];
	step_row_t   plan[$];
	int          mismatches = 0;
	bit          cfg_active = 1'b0;
	bit          burst = 1'b0;

	rect_fill_and_gray_blit_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .source_gray(source_gray),
		.out_valid(out_valid), .out_stall(out_stall),
		.pixel_addr(pixel_addr), .blue(blue), .green(green), .red(red), .alpha(alpha),
		.write_enable(write_enable), .bounds_error(bounds_error), .last_pixel(last_pixel)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Zero side counts as one, oversize sides saturate
	function automatic int unsigned clamp_side(input logic [DIM_W-1:0] v);
		if (v == '0) return 1;
		if (32'(v) > MAX_DIM_DEF) return MAX_DIM_DEF;
		return 32'(v);
	endfunction

	// Expected write for the next pixel beat; advances the walk
	function automatic blit_write_t predict_write(input logic [BYTE_W-1:0] gray);
		int unsigned       w, h, col, row;
		longint unsigned   xa, ya;
		blit_write_t       res;
		bit                fits;
		w    = clamp_side(reg_rw);
		h    = clamp_side(reg_rh);
		col  = walk_col;
		row  = walk_row;
		fits = (32'(reg_dx) + w <= 32'(reg_sw)) && (32'(reg_dy) + h <= 32'(reg_sh));
		xa   = 64'(reg_dx) + col;
		ya   = 64'(reg_dy) + row;
		res.addr = ADDR_W'(ya * 64'(reg_sw) + xa);
		if (col >= w) col = w - 1;
		if (row >= h) row = h - 1;
		res.last = (col == w - 1) && (row == h - 1);
		res.b    = reg_fill_mode ? reg_fill_level : gray;
		res.g    = res.b;
		res.r    = res.b;
		res.a    = reg_fill_mode ? reg_fill_level : 8'hFF;
		res.we   = fits;
		res.err  = !fits;
		if (col + 1 < w) begin
			walk_col = col + 1;
			walk_row = row;
		end else begin
			walk_col = 0;
			walk_row = (row + 1 < h) ? row + 1 : 0;
		end
		return res;
	endfunction

	function automatic blit_write_t write_of(input logic [ADDR_W-1:0] addr,
	                                         input logic [BYTE_W-1:0] chan,
	                                         input logic [BYTE_W-1:0] a,
	                                         input logic we, input logic err,
	                                         input logic last);
		blit_write_t res;
		res = '{addr: addr, b: chan, g: chan, r: chan, a: a, we: we, err: err, last: last};
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 12);
		return $urandom_range(30, 80);
	endfunction

	// Table builders
	function automatic void plan_cfg(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
		plan.push_back('{1'b1, idx, data, 8'h00, 1'b0, '0});
	endfunction

	function automatic void plan_pix(input logic [BYTE_W-1:0] gray);
		plan.push_back('{1'b0, CFG_DEST_X, '0, gray, 1'b0, '0});
	endfunction

	function automatic void plan_typed(input logic [BYTE_W-1:0] gray, input blit_write_t res);
		plan.push_back('{1'b0, CFG_DEST_X, '0, gray, 1'b1, res});
	endfunction

	// Register write; cfg_we stays high until the next pixel beat lowers it
	task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
		cfg_we     <= 1'b1;
		cfg_index  <= idx;
		cfg_data   <= data;
		cfg_active = 1'b1;
		@(posedge clk);
		case (idx)
			CFG_DEST_X:         reg_dx = data[POS_W-1:0];
			CFG_DEST_Y:         reg_dy = data[POS_W-1:0];
			CFG_RECT_WIDTH:     reg_rw = data;
			CFG_RECT_HEIGHT:    reg_rh = data;
			CFG_SURFACE_WIDTH:  reg_sw = data;
			CFG_SURFACE_HEIGHT: reg_sh = data;
			CFG_FILL_MODE:      reg_fill_mode = data[0];
			CFG_FILL_LEVEL:     reg_fill_level = data[BYTE_W-1:0];
			default: ;
		endcase
		walk_col = 0;
		walk_row = 0;
	endtask

	// One pixel beat; valid is left high so a following beat can go back to back
	task automatic send_pixel(input logic [BYTE_W-1:0] gray, input bit typed,
	                          input blit_write_t res);
		int          gap;
		blit_write_t pred;
		if (cfg_active) begin
			cfg_we     <= 1'b0;
			cfg_active = 1'b0;
		end
		gap = burst ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pred = predict_write(gray);
		due_writes.push_back(typed ? res : pred);
		in_valid    <= 1'b1;
		source_gray <= gray;
		do @(posedge clk); while (in_stall);
	endtask

	// Hold the sender until every predicted write has come out
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (due_writes.size() != 0) @(posedge clk);
	endtask

	task automatic report_field(input string name, input logic [ADDR_W-1:0] want,
	                            input logic [ADDR_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Output side back-pressure, with occasional long quiet stretches
	initial begin : stall_gen
		int n;
		forever begin
			n = pick_gap();
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat (($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 8))
				@(posedge clk);
		end
	end

	// Compare each accepted write beat with the oldest prediction
	always @(posedge clk) begin : result_check
		blit_write_t want, got;
		if (arst_n && out_valid && !out_stall) begin
			got = {pixel_addr, blue, green, red, alpha, write_enable, bounds_error, last_pixel};
			if (due_writes.size() == 0) begin
				$display("%0t: unexpected write beat, got %h", $time, got);
				mismatches++;
			end else begin
				want = due_writes.pop_front();
				report_field("pixel_addr", want.addr, got.addr);
				report_field("blue", want.b, got.b);
				report_field("green", want.g, got.g);
				report_field("red", want.r, got.r);
				report_field("alpha", want.a, got.a);
				report_field("write_enable", want.we, got.we);
				report_field("bounds_error", want.err, got.err);
				report_field("last_pixel", want.last, got.last);
			end
		end
	end

	initial begin : watchdog
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin : stimulus
		int          sent, n, r, area, first;
		logic [CFG_W-1:0] vals [8];
		bit          subset;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset state: 1x1 rectangle on a 1x1 surface, gray copy
		plan_typed(8'hA5, write_of(24'd0, 8'hA5, 8'hFF, 1'b1, 1'b0, 1'b1));
		plan_typed(8'h00, write_of(24'd0, 8'h00, 8'hFF, 1'b1, 1'b0, 1'b1));
		plan_typed(8'hFF, write_of(24'd0, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b1));
		// Fill mode at both level extremes
		plan_cfg(CFG_FILL_MODE, 13'd1);
		plan_cfg(CFG_FILL_LEVEL, 13'hFF);
		plan_typed(8'h12, write_of(24'd0, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b1));
		plan_cfg(CFG_FILL_LEVEL, 13'h00);
		plan_typed(8'hFF, write_of(24'd0, 8'h00, 8'h00, 1'b1, 1'b0, 1'b1));
		// Out of bounds horizontally, then vertically
		plan_cfg(CFG_DEST_X, 13'd1);
		plan_typed(8'h3C, write_of(24'd1, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1));
		plan_cfg(CFG_DEST_X, 13'd0);
		plan_cfg(CFG_DEST_Y, 13'd1);
		plan_typed(8'h3C, write_of(24'd1, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1));
		// Zero rectangle width counts as one
		plan_cfg(CFG_DEST_Y, 13'd0);
		plan_cfg(CFG_FILL_MODE, 13'd0);
		plan_cfg(CFG_RECT_WIDTH, 13'd0);
		plan_typed(8'h5A, write_of(24'd0, 8'h5A, 8'hFF, 1'b1, 1'b0, 1'b1));
		// Zero surface width: everything suppressed
		plan_cfg(CFG_RECT_HEIGHT, 13'd0);
		plan_cfg(CFG_SURFACE_WIDTH, 13'd0);
		plan_typed(8'hC3, write_of(24'd0, 8'hC3, 8'hFF, 1'b0, 1'b1, 1'b1));
		// Zero surface height
		plan_cfg(CFG_SURFACE_WIDTH, 13'h1FFF);
		plan_cfg(CFG_SURFACE_HEIGHT, 13'd0);
		plan_pix(8'h81);
		// Far corner of the largest surface, clamped width, address wraps at 24 bits
		plan_cfg(CFG_SURFACE_HEIGHT, 13'h1FFF);
		plan_cfg(CFG_DEST_X, 13'h1FFF);
		plan_cfg(CFG_DEST_Y, 13'h0FFF);
		plan_cfg(CFG_RECT_WIDTH, 13'h1FFF);
		plan_cfg(CFG_RECT_HEIGHT, 13'd2);
		plan_pix(8'h01);
		plan_pix(8'h80);
		plan_pix(8'h7F);
		// Small walk with last pixel and wrap to the corner
		plan_cfg(CFG_DEST_X, 13'd1);
		plan_cfg(CFG_DEST_Y, 13'd2);
		plan_cfg(CFG_RECT_WIDTH, 13'd3);
		plan_cfg(CFG_RECT_HEIGHT, 13'd2);
		plan_cfg(CFG_SURFACE_WIDTH, 13'd4);
		plan_cfg(CFG_SURFACE_HEIGHT, 13'd4);
		for (int k = 0; k < 7; k++) plan_pix(8'(8'h10 + k));
		// Register write mid-walk restarts; width just over the limit saturates
		plan_cfg(CFG_RECT_WIDTH, 13'd4097);
		plan_pix(8'h55);
		plan_pix(8'hAA);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				if (!cfg_active) wait_idle();
				cfg_write(plan[i].idx, plan[i].data);
			end else begin
				send_pixel(plan[i].gray, plan[i].typed, plan[i].res);
			end
		end

		// Random rectangles, one per phase, reprogrammed only when drained
		sent = 0;
		while (sent < 650) begin
			wait_idle();
			burst = ($urandom_range(0, 4) == 0);
			r = $urandom_range(0, 9);
			if (r < 7) begin
				// fits on a small surface
				vals[CFG_SURFACE_WIDTH]  = 13'($urandom_range(1, 12));
				vals[CFG_SURFACE_HEIGHT] = 13'($urandom_range(1, 12));
				vals[CFG_RECT_WIDTH]     = 13'($urandom_range(1, vals[CFG_SURFACE_WIDTH]));
				vals[CFG_RECT_HEIGHT]    = 13'($urandom_range(1, vals[CFG_SURFACE_HEIGHT]));
				vals[CFG_DEST_X] = 13'($urandom_range(0,
					vals[CFG_SURFACE_WIDTH] - vals[CFG_RECT_WIDTH]));
				vals[CFG_DEST_Y] = 13'($urandom_range(0,
					vals[CFG_SURFACE_HEIGHT] - vals[CFG_RECT_HEIGHT]));
				if (vals[CFG_RECT_WIDTH] == 13'd1 && $urandom_range(0, 1)) vals[CFG_RECT_WIDTH] = '0;
			end else if (r < 9) begin
				// loose small values, often out of bounds
				vals[CFG_SURFACE_WIDTH]  = 13'($urandom_range(0, 16));
				vals[CFG_SURFACE_HEIGHT] = 13'($urandom_range(0, 16));
				vals[CFG_RECT_WIDTH]     = 13'($urandom_range(0, 8));
				vals[CFG_RECT_HEIGHT]    = 13'($urandom_range(0, 8));
				vals[CFG_DEST_X]         = 13'($urandom_range(0, 12));
				vals[CFG_DEST_Y]         = 13'($urandom_range(0, 12));
			end else begin
				// full-width words, short rectangles
				vals[CFG_SURFACE_WIDTH]  = 13'($urandom());
				vals[CFG_SURFACE_HEIGHT] = 13'($urandom());
				vals[CFG_RECT_WIDTH]     = 13'($urandom());
				vals[CFG_RECT_HEIGHT]    = 13'($urandom_range(1, 3));
				vals[CFG_DEST_X]         = 13'($urandom());
				vals[CFG_DEST_Y]         = 13'($urandom());
			end
			vals[CFG_FILL_MODE]  = 13'($urandom_range(0, 1));
			vals[CFG_FILL_LEVEL] = 13'($urandom());

			// all registers in a rotated order, or a random subset of them
			subset = ($urandom_range(0, 2) == 0);
			first  = $urandom_range(0, 7);
			for (int k = 0; k < 8; k++) begin
				if (!subset || $urandom_range(0, 1))
					cfg_write(cfg_idx_t'((first + k) % 8), vals[(first + k) % 8]);
			end

			area = clamp_side(reg_rw) * clamp_side(reg_rh);
			if (area <= 15) n = area * $urandom_range(1, 3) + $urandom_range(0, 3);
			else n = $urandom_range(5, 30);
			repeat (n) send_pixel(8'($urandom()), 1'b0, '0);
			sent += n;
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
